[design/lfcs_pkg.sv]
// Shared types, codes and constants of the laser frame color shifter.
`timescale 1ns / 1ps
`default_nettype none

package lfcs_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SHIFT_DEF         = 63;
    localparam int FRAME_SAMPLES_MAX_DEF = 65535;

    // Field and storage widths.
    localparam int SHIFT_W    = 6;
    localparam int SPEED_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 16;
    localparam int RGB_W      = 24;
    localparam int DUR_W      = 24;
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Duration arithmetic: (samples - 1) * 1e6 / scan_speed.
    localparam int                 TOTAL_W    = COUNT_W + 1;
    localparam int                 QUO_W      = 36;
    localparam logic [SPEED_W-1:0] DUR_SCALE  = SPEED_W'(1000000);
    localparam int                 DIV_STEPS  = QUO_W;
    localparam int                 STEP_W     = $clog2(DIV_STEPS);
    localparam logic [DUR_W-1:0]   DUR_MAX    = {DUR_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_RST  = SPEED_W'(30000);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_COLOR_SHIFT = 2'd0;
    localparam logic [1:0] REG_SCAN_SPEED  = 2'd1;
    localparam logic [1:0] REG_JITTER_FREE = 2'd2;

    // Input action codes.
    localparam logic [1:0] ACT_OPEN = 2'd0;
    localparam logic [1:0] ACT_PUT  = 2'd1;
    localparam logic [1:0] ACT_PUSH = 2'd2;

    // Minimum number of puts before a push closes the frame.
    localparam logic [COUNT_W-1:0] MIN_PUSH_SAMPLES = COUNT_W'(2);

    typedef enum logic [2:0] {
        KIND_SAMPLE    = 3'd0,
        KIND_FRAME_END = 3'd1,
        KIND_NOT_OPEN  = 3'd2,
        KIND_TOO_FEW   = 3'd3,
        KIND_FULL      = 3'd4
    } lfcs_kind_t;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_PUSH   = 2'd1,
        OP_ERROR  = 2'd2
    } lfcs_op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EMIT,
        BK_TAIL_RD,
        BK_TAIL_OUT,
        BK_MUL,
        BK_DIV,
        BK_END
    } lfcs_bstate_t;

    // One command from the front to the back.
    typedef struct packed {
        lfcs_op_t           op;
        lfcs_kind_t         kind;
        logic [COUNT_W-1:0] index;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [RGB_W-1:0]   rgb;
        logic               once;
    } lfcs_cmd_t;

    // One result item.
    typedef struct packed {
        lfcs_kind_t              kind;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic [7:0]              red_out;
        logic [7:0]              green_out;
        logic [7:0]              blue_out;
        logic [DUR_W-1:0]        duration_us;
        logic                    scan_once;
        logic                    last;
    } lfcs_result_t;

endpackage

`default_nettype wire

[design/lfcs_cmd_queue.sv]
// Small command queue that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none

module lfcs_cmd_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire lfcs_pkg::lfcs_cmd_t push_cmd,
    output logic                     full,
    input  wire logic                pop,
    output lfcs_pkg::lfcs_cmd_t      head,
    output logic                     head_valid
);

    localparam int DEPTH = lfcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    lfcs_pkg::lfcs_cmd_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]    level_reg, level_next;

    assign full       = (level_reg == LVL_W'(DEPTH));
    assign head_valid = (level_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/lfcs_front.sv]
// Front end: accepts requests, tracks the frame state and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module lfcs_front
#(
    parameter int FRAME_SAMPLES_MAX = lfcs_pkg::FRAME_SAMPLES_MAX_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         action,
    input  wire logic [lfcs_pkg::POS_W-1:0]         pos_x,
    input  wire logic [lfcs_pkg::POS_W-1:0]         pos_y,
    input  wire logic [lfcs_pkg::RGB_W-1:0]         rgb,
    input  wire logic                               jitter_free,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output lfcs_pkg::lfcs_cmd_t                     q_cmd
);

    logic                           open_reg, open_next;
    logic                           first_done_reg, first_done_next;
    logic [lfcs_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the request and build the command for the back end.
    always_comb
    begin
        open_next       = open_reg;
        first_done_next = first_done_reg;
        count_next      = count_reg;
        q_push          = 1'b0;
        q_cmd.op        = lfcs_pkg::OP_ERROR;
        q_cmd.kind      = lfcs_pkg::KIND_NOT_OPEN;
        q_cmd.index     = count_reg;
        q_cmd.pos_x     = pos_x;
        q_cmd.pos_y     = pos_y;
        q_cmd.rgb       = rgb;
        q_cmd.once      = 1'b0;
        if (accept)
        begin
            case (action)
                lfcs_pkg::ACT_OPEN:
                begin
                    open_next  = 1'b1;
                    count_next = '0;
                end
                lfcs_pkg::ACT_PUT:
                begin
                    q_push = 1'b1;
                    if (!open_reg)
                    begin
                        q_cmd.kind = lfcs_pkg::KIND_NOT_OPEN;
                    end
                    else if (count_reg >= lfcs_pkg::COUNT_W'(FRAME_SAMPLES_MAX))
                    begin
                        q_cmd.kind = lfcs_pkg::KIND_FULL;
                    end
                    else
                    begin
                        q_cmd.op   = lfcs_pkg::OP_SAMPLE;
                        q_cmd.kind = lfcs_pkg::KIND_SAMPLE;
                        count_next = count_reg + 1'b1;
                    end
                end
                lfcs_pkg::ACT_PUSH:
                begin
                    q_push = 1'b1;
                    if (!open_reg)
                    begin
                        q_cmd.kind = lfcs_pkg::KIND_NOT_OPEN;
                    end
                    else if (count_reg < lfcs_pkg::MIN_PUSH_SAMPLES)
                    begin
                        q_cmd.kind = lfcs_pkg::KIND_TOO_FEW;
                    end
                    else
                    begin
                        q_cmd.op        = lfcs_pkg::OP_PUSH;
                        q_cmd.kind      = lfcs_pkg::KIND_FRAME_END;
                        q_cmd.once      = jitter_free && first_done_reg;
                        first_done_next = 1'b1;
                        open_next       = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            first_done_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            open_reg       <= open_next;
            first_done_reg <= first_done_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/lfcs_back.sv]
// Back end: color ring, tail emission, duration divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module lfcs_back
#(
    parameter int MAX_SHIFT = lfcs_pkg::MAX_SHIFT_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire lfcs_pkg::lfcs_cmd_t           q_cmd,
    output logic                               q_pop,
    input  wire logic [lfcs_pkg::SHIFT_W-1:0]  color_shift,
    input  wire logic [lfcs_pkg::SPEED_W-1:0]  scan_speed,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lfcs_pkg::lfcs_result_t             out_result
);

    localparam int SHIFT_W = lfcs_pkg::SHIFT_W;
    localparam int RING_AW = lfcs_pkg::RING_AW;
    localparam int TOTAL_W = lfcs_pkg::TOTAL_W;
    localparam int QUO_W   = lfcs_pkg::QUO_W;
    localparam int SPEED_W = lfcs_pkg::SPEED_W;
    localparam int DUR_W   = lfcs_pkg::DUR_W;
    localparam int STEP_W  = lfcs_pkg::STEP_W;
    localparam int RGB_W   = lfcs_pkg::RGB_W;
    localparam int PROD_W  = TOTAL_W + SPEED_W;

    lfcs_pkg::lfcs_bstate_t   state_reg, state_next;
    lfcs_pkg::lfcs_cmd_t      cmd_reg;
    lfcs_pkg::lfcs_result_t   out_reg, out_next;
    logic                     out_valid_reg;
    logic [2*lfcs_pkg::POS_W-1:0] last_pos_reg;
    logic [SHIFT_W-1:0]       tail_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [SPEED_W-1:0]       rem_reg;
    logic [RGB_W-1:0]         ring_mem [lfcs_pkg::RING_DEPTH];
    logic [RGB_W-1:0]         rd_data_reg;

    logic [SHIFT_W-1:0]       shift;
    logic                     out_free;
    logic                     out_load;
    logic                     ring_we;
    logic                     rd_en;
    logic [RING_AW-1:0]       rd_addr;
    logic [RING_AW-1:0]       head_addr;
    logic [TOTAL_W-1:0]       tail_idx;
    logic [RING_AW-1:0]       tail_addr;
    logic                     tail_zero;
    logic                     samp_zero;
    logic [RGB_W-1:0]         samp_color;
    logic [TOTAL_W-1:0]       total_m1;
    logic [PROD_W-1:0]        prod;
    logic [SPEED_W:0]         rem_sh;
    logic                     div_ge;
    logic [SPEED_W:0]         div_diff;
    logic [DUR_W-1:0]         dur;

    // Shift in effect, clamped to the supported maximum.
    assign shift = (color_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : color_shift;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Ring addressing for a new sample and for the tail of a frame.
    assign head_addr  = q_cmd.index[RING_AW-1:0] - RING_AW'(shift);
    assign tail_idx   = {1'b0, cmd_reg.index} + TOTAL_W'(tail_reg);
    assign tail_addr  = tail_idx[RING_AW-1:0] - RING_AW'(shift);
    assign tail_zero  = (tail_idx < TOTAL_W'(shift));

    // Color of a sample: zero before the shift, the just-written color at zero shift.
    assign samp_zero  = (cmd_reg.index < lfcs_pkg::COUNT_W'(shift));
    assign samp_color = samp_zero ? '0 : ((shift == '0) ? cmd_reg.rgb : rd_data_reg);

    // Duration numerator.
    assign total_m1 = {1'b0, cmd_reg.index} + TOTAL_W'(shift) - TOTAL_W'(1);
    assign prod     = PROD_W'(total_m1) * PROD_W'(lfcs_pkg::DUR_SCALE);

    // One restoring division step.
    assign rem_sh   = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, scan_speed});
    assign div_diff = rem_sh - {1'b0, scan_speed};

    assign dur = ((scan_speed == '0) || (quo_reg[QUO_W-1:DUR_W] != '0))
               ? lfcs_pkg::DUR_MAX : quo_reg[DUR_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfcs_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.op == lfcs_pkg::OP_PUSH)
                    begin
                        state_next = (shift == '0) ? lfcs_pkg::BK_MUL : lfcs_pkg::BK_TAIL_RD;
                    end
                    else
                    begin
                        state_next = lfcs_pkg::BK_EMIT;
                    end
                end
            end
            lfcs_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lfcs_pkg::BK_IDLE;
                end
            end
            lfcs_pkg::BK_TAIL_RD:
            begin
                state_next = lfcs_pkg::BK_TAIL_OUT;
            end
            lfcs_pkg::BK_TAIL_OUT:
            begin
                if (out_free)
                begin
                    state_next = (tail_reg == shift - 1'b1)
                               ? lfcs_pkg::BK_MUL : lfcs_pkg::BK_TAIL_RD;
                end
            end
            lfcs_pkg::BK_MUL:
            begin
                state_next = lfcs_pkg::BK_DIV;
            end
            lfcs_pkg::BK_DIV:
            begin
                if (step_reg == STEP_W'(lfcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = lfcs_pkg::BK_END;
                end
            end
            lfcs_pkg::BK_END:
            begin
                if (out_free)
                begin
                    state_next = lfcs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lfcs_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, ring access and result formation.
    always_comb
    begin
        q_pop    = 1'b0;
        ring_we  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = head_addr;
        out_load = 1'b0;
        out_next = '0;
        case (state_reg)
            lfcs_pkg::BK_IDLE:
            begin
                q_pop   = q_valid;
                ring_we = q_valid && (q_cmd.op == lfcs_pkg::OP_SAMPLE);
                rd_en   = q_valid;
            end
            lfcs_pkg::BK_EMIT:
            begin
                out_load      = out_free;
                out_next.last = 1'b1;
                if (cmd_reg.op == lfcs_pkg::OP_SAMPLE)
                begin
                    out_next.kind      = lfcs_pkg::KIND_SAMPLE;
                    out_next.out_x     = cmd_reg.pos_x;
                    out_next.out_y     = cmd_reg.pos_y;
                    out_next.red_out   = samp_color[23:16];
                    out_next.green_out = samp_color[15:8];
                    out_next.blue_out  = samp_color[7:0];
                end
                else
                begin
                    out_next.kind = cmd_reg.kind;
                end
            end
            lfcs_pkg::BK_TAIL_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = tail_addr;
            end
            lfcs_pkg::BK_TAIL_OUT:
            begin
                out_load           = out_free;
                out_next.kind      = lfcs_pkg::KIND_SAMPLE;
                out_next.out_x     = last_pos_reg[31:16];
                out_next.out_y     = last_pos_reg[15:0];
                out_next.red_out   = tail_zero ? 8'd0 : rd_data_reg[23:16];
                out_next.green_out = tail_zero ? 8'd0 : rd_data_reg[15:8];
                out_next.blue_out  = tail_zero ? 8'd0 : rd_data_reg[7:0];
            end
            lfcs_pkg::BK_END:
            begin
                out_load             = out_free;
                out_next.kind        = lfcs_pkg::KIND_FRAME_END;
                out_next.duration_us = dur;
                out_next.scan_once   = cmd_reg.once;
                out_next.last        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfcs_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            tail_reg      <= '0;
            step_reg      <= '0;
            last_pos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                tail_reg <= '0;
            end
            else if ((state_reg == lfcs_pkg::BK_TAIL_OUT) && out_free)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (state_reg == lfcs_pkg::BK_MUL)
            begin
                step_reg <= '0;
            end
            else if (state_reg == lfcs_pkg::BK_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (ring_we)
            begin
                last_pos_reg <= {q_cmd.pos_x, q_cmd.pos_y};
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (state_reg == lfcs_pkg::BK_MUL)
        begin
            quo_reg <= prod[QUO_W-1:0];
            rem_reg <= '0;
        end
        else if (state_reg == lfcs_pkg::BK_DIV)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
        end
    end

    // Color ring: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[q_cmd.index[RING_AW-1:0]] <= q_cmd.rgb;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/laser_frame_color_shift.sv]
// Top level of the laser frame color shifter: register port and stream channels.
//
// Point frames arrive on the slave stream: s_tuser carries the action (open, put,
// push) and s_tdata the position and color of a put. Results leave on the master
// stream: m_tuser carries the result kind, m_tdata the shifted sample or the
// frame-end duration and scan-once flag, and m_tlast marks the last result of a
// request. Color lags position by color_shift samples, set over the register port.
// A front end classifies requests and keeps the frame count; a four-entry command
// queue feeds the back end, which owns the 64-entry color ring.
// In the back end a put pops the queue with its ring write and read, then loads the
// output register. A push leaves the queue, reads and emits each tail sample, then
// multiplies, runs the bit-serial divider and loads the frame-end result; an error
// pops the queue and then loads its result. Reset closes any frame, clears the queue
// and the output valid flag and loads the register defaults. When m_tready is low the
// result waits in the output register, the back end stops and the queue fills;
// s_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module laser_frame_color_shift
#(
    parameter int MAX_SHIFT         = lfcs_pkg::MAX_SHIFT_DEF,
    parameter int FRAME_SAMPLES_MAX = lfcs_pkg::FRAME_SAMPLES_MAX_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Register port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lfcs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lfcs_pkg::DATA_W-1:0]  pwdata,
    output logic      [lfcs_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    // Request stream.
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [55:0]                  s_tdata,  // pos_x, pos_y, red_in, green_in, blue_in
    input  wire logic [1:0]                   s_tuser,  // action
    // Result stream.
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [87:0]                       m_tdata,  // out_x, out_y, red_out, green_out,
                                                        // blue_out, duration_us, scan_once
    output logic [2:0]                        m_tuser,  // kind
    output logic                              m_tlast
);

    logic [lfcs_pkg::SHIFT_W-1:0]  color_shift_reg;
    logic [lfcs_pkg::SPEED_W-1:0]  scan_speed_reg;
    logic                          jitter_free_reg;
    logic                          cfg_write;
    logic [1:0]                    reg_index;

    logic                          q_full;
    logic                          q_push;
    lfcs_pkg::lfcs_cmd_t           q_push_cmd;
    logic                          q_pop;
    lfcs_pkg::lfcs_cmd_t           q_head;
    logic                          q_head_valid;
    lfcs_pkg::lfcs_result_t        result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_shift_reg <= '0;
            scan_speed_reg  <= lfcs_pkg::SPEED_RST;
            jitter_free_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                lfcs_pkg::REG_COLOR_SHIFT: color_shift_reg <= pwdata[lfcs_pkg::SHIFT_W-1:0];
                lfcs_pkg::REG_SCAN_SPEED:  scan_speed_reg  <= pwdata[lfcs_pkg::SPEED_W-1:0];
                lfcs_pkg::REG_JITTER_FREE: jitter_free_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            lfcs_pkg::REG_COLOR_SHIFT: prdata = lfcs_pkg::DATA_W'(color_shift_reg);
            lfcs_pkg::REG_SCAN_SPEED:  prdata = lfcs_pkg::DATA_W'(scan_speed_reg);
            lfcs_pkg::REG_JITTER_FREE: prdata = lfcs_pkg::DATA_W'(jitter_free_reg);
            default:                   prdata = '0;
        endcase
    end

    lfcs_front #(
        .FRAME_SAMPLES_MAX (FRAME_SAMPLES_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .action      (s_tuser),
        .pos_x       (s_tdata[15:0]),
        .pos_y       (s_tdata[31:16]),
        .rgb         ({s_tdata[39:32], s_tdata[47:40], s_tdata[55:48]}),
        .jitter_free (jitter_free_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    lfcs_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    lfcs_back #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_head_valid),
        .q_cmd       (q_head),
        .q_pop       (q_pop),
        .color_shift (color_shift_reg),
        .scan_speed  (scan_speed_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // Result packing.
    assign m_tuser = result.kind;
    assign m_tlast = result.last;
    assign m_tdata = {7'd0, result.scan_once, result.duration_us, result.blue_out,
                      result.green_out, result.red_out, result.out_y, result.out_x};

endmodule

`default_nettype wire

[tb/tb_laser_frame_color_shift.sv]
// Self-checking stream testbench for the laser frame color shifter.
`timescale 1ns / 1ps

module tb_laser_frame_color_shift;

    import lfcs_pkg::*;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 7;
    localparam int          CYCLE_LIMIT     = 3000000;
    localparam int          SETTLE_GAP      = 20;
    localparam int          END_GAP         = 200;
    localparam int          RANDOM_REQUESTS = 410;
    localparam int          SEGMENTS        = 8;
    localparam int          HOLD_CYCLES     = 600;
    localparam int          FRAME_MAX       = FRAME_SAMPLES_MAX_DEF;
    localparam logic [1:0]  ACT_UNUSED      = 2'd3;
    localparam logic [19:0] SPEED_MAX       = 20'hFFFFF;
    localparam longint unsigned USEC_PER_SEC = 64'd1000000;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0]
    {
        ROW_REQUEST,
        ROW_CHECKED,
        ROW_REG_WRITE
    } row_kind_t;

    typedef struct
    {
        row_kind_t    row;
        logic [1:0]   act;   // action, or register index for a register write
        logic [55:0]  data;  // request payload, or register value
        lfcs_result_t want;  // typed-in result of a checked row
    } plan_row_t;

    // Clock, reset and block ports.
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata  = '0;  // pos_x, pos_y, red_in, green_in, blue_in
    logic [1:0]  s_tuser  = '0;  // action
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [87:0] m_tdata;        // out_x, out_y, red_out, green_out, blue_out,
                                 // duration_us, scan_once
    wire  [2:0]  m_tuser;        // kind
    wire         m_tlast;

    // Shadow of the block: registers and frame state.
    logic [5:0]  shift_setting  = 6'd0;
    logic [19:0] speed_setting  = 20'd30000;
    logic        jitter_setting = 1'b0;
    logic [23:0] color_ring [RING_DEPTH];
    logic [5:0]  ring_wr        = '0;
    int          puts_in_frame  = 0;
    logic [15:0] last_x         = '0;
    logic [15:0] last_y         = '0;
    logic        frame_is_open  = 1'b0;
    logic        frame_pushed   = 1'b0;

    lfcs_result_t results_due [$];
    plan_row_t    test_plan [$];

    int mismatch_count     = 0;
    int requests_sent      = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_request       = 0;
    int hold_left          = 0;

    laser_frame_color_shift uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #CLK_HALF clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [55:0] payload(logic [15:0] x, logic [15:0] y, logic [23:0] rgb);
        return {rgb[7:0], rgb[15:8], rgb[23:16], y, x};
    endfunction

    function automatic logic [55:0] random_payload();
        logic [55:0] p;
        p = 56'({$urandom, $urandom});
        return p;
    endfunction

    function automatic lfcs_result_t typed_result(lfcs_kind_t kind, logic [15:0] x,
                                                  logic [15:0] y, logic [23:0] rgb,
                                                  logic [23:0] dur);
        lfcs_result_t r;
        r             = '0;
        r.kind        = kind;
        r.out_x       = x;
        r.out_y       = y;
        r.red_out     = rgb[23:16];
        r.green_out   = rgb[15:8];
        r.blue_out    = rgb[7:0];
        r.duration_us = dur;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic plan_row_t plain_row(logic [1:0] act, logic [55:0] data);
        plan_row_t r;
        r.row  = ROW_REQUEST;
        r.act  = act;
        r.data = data;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(logic [1:0] act, logic [55:0] data,
                                              lfcs_result_t want);
        plan_row_t r;
        r      = plain_row(act, data);
        r.row  = ROW_CHECKED;
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t register_row(logic [1:0] idx, logic [31:0] value);
        plan_row_t r;
        r     = plain_row(idx, {24'd0, value});
        r.row = ROW_REG_WRITE;
        return r;
    endfunction

    // Color of sample k in the current frame under the current shift.
    function automatic logic [23:0] lagged_color(int k);
        logic [5:0] slot;
        if (k < int'(shift_setting))
            return '0;
        slot = 6'(int'(ring_wr) - puts_in_frame + k - int'(shift_setting));
        return color_ring[slot];
    endfunction

    // Work out the results of one accepted request and queue them.
    task automatic predict_request(input logic [1:0] act, input logic [55:0] data);
        lfcs_result_t     r;
        int               i;
        int               total;
        longint unsigned  span;
        logic [23:0]      dur;
        case (act)
            ACT_OPEN:
            begin
                frame_is_open = 1'b1;
                puts_in_frame = 0;
                ring_wr       = '0;
            end
            ACT_PUT:
            begin
                if (!frame_is_open)
                    results_due.push_back(typed_result(KIND_NOT_OPEN, '0, '0, '0, '0));
                else if (puts_in_frame >= FRAME_MAX)
                    results_due.push_back(typed_result(KIND_FULL, '0, '0, '0, '0));
                else
                begin
                    color_ring[ring_wr] = {data[39:32], data[47:40], data[55:48]};
                    ring_wr             = ring_wr + 6'd1;
                    puts_in_frame++;
                    last_x = data[15:0];
                    last_y = data[31:16];
                    results_due.push_back(typed_result(KIND_SAMPLE, last_x, last_y,
                                                       lagged_color(puts_in_frame - 1), '0));
                end
            end
            ACT_PUSH:
            begin
                if (!frame_is_open)
                    results_due.push_back(typed_result(KIND_NOT_OPEN, '0, '0, '0, '0));
                else if (puts_in_frame < 2)
                    results_due.push_back(typed_result(KIND_TOO_FEW, '0, '0, '0, '0));
                else
                begin
                    // Tail samples repeat the last position with the remaining colors.
                    for (i = 0; i < int'(shift_setting); i++)
                    begin
                        r      = typed_result(KIND_SAMPLE, last_x, last_y,
                                              lagged_color(puts_in_frame + i), '0);
                        r.last = 1'b0;
                        results_due.push_back(r);
                    end
                    total = puts_in_frame + int'(shift_setting);
                    if (speed_setting == 0)
                        dur = DUR_MAX;
                    else
                    begin
                        span = longint'(total - 1) * USEC_PER_SEC / speed_setting;
                        dur  = (span > DUR_MAX) ? DUR_MAX : span[23:0];
                    end
                    r           = typed_result(KIND_FRAME_END, '0, '0, '0, dur);
                    r.scan_once = jitter_setting && frame_pushed;
                    results_due.push_back(r);
                    frame_pushed  = 1'b1;
                    frame_is_open = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_request(input logic [1:0] act, input logic [55:0] data);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= random_payload();
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(act, data);
        if (act != ACT_UNUSED)
            requests_sent++;
    endtask

    // Stop offering and wait until every queued result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Register write on an idle block: setup cycle, then access cycle.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COLOR_SHIFT: shift_setting  = value[5:0];
            REG_SCAN_SPEED:  speed_setting  = value[19:0];
            REG_JITTER_FREE: jitter_setting = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        lfcs_result_t want;
        if (results_due.size() == 0)
        begin
            $display("%0t: result with none expected: kind %h tdata %h last %b",
                     $time, m_tuser, m_tdata, m_tlast);
            mismatch_count++;
        end
        else
        begin
            want = results_due.pop_front();
            compare_field("kind", want.kind, m_tuser);
            compare_field("out_x", {16'd0, want.out_x}, m_tdata[15:0]);
            compare_field("out_y", {16'd0, want.out_y}, m_tdata[31:16]);
            compare_field("red_out", want.red_out, m_tdata[39:32]);
            compare_field("green_out", want.green_out, m_tdata[47:40]);
            compare_field("blue_out", want.blue_out, m_tdata[55:48]);
            compare_field("duration_us", want.duration_us, m_tdata[79:56]);
            compare_field("scan_once", want.scan_once, m_tdata[80]);
            compare_field("last", want.last, m_tlast);
        end
    endtask

    // Result side: check each accepted result, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // One random stretch: mostly whole frames, some broken frames and noise.
    task automatic random_burst();
        int roll;
        int len;
        int k;
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            send_request(ACT_OPEN, random_payload());
            len = ($urandom_range(7) == 0) ? $urandom_range(60, 100) : $urandom_range(2, 14);
            for (k = 0; k < len; k++)
            begin
                // Now and then the shift moves inside the frame.
                if ($urandom_range(59) == 0)
                    write_register(REG_COLOR_SHIFT, $urandom_range(63));
                send_request(ACT_PUT, random_payload());
            end
            send_request(ACT_PUSH, random_payload());
        end
        else if (roll < 88)
        begin
            // Push too early; the frame stays open for whatever follows.
            send_request(ACT_OPEN, random_payload());
            len = $urandom_range(1);
            for (k = 0; k < len; k++)
                send_request(ACT_PUT, random_payload());
            send_request(ACT_PUSH, random_payload());
        end
        else
        begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++)
                send_request(2'($urandom_range(3)), random_payload());
        end
    endtask

    initial
    begin
        int          seg;
        int          goal;
        logic [31:0] speed;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset register values.
        test_plan.push_back(checked_row(ACT_PUT, payload(16'h1234, 16'h5678, 24'hABCDEF),
                                        typed_result(KIND_NOT_OPEN, '0, '0, '0, '0)));
        test_plan.push_back(checked_row(ACT_PUSH, '0,
                                        typed_result(KIND_NOT_OPEN, '0, '0, '0, '0)));
        test_plan.push_back(plain_row(ACT_UNUSED, '1));
        test_plan.push_back(plain_row(ACT_OPEN, '0));
        test_plan.push_back(checked_row(ACT_PUSH, '0,
                                        typed_result(KIND_TOO_FEW, '0, '0, '0, '0)));
        test_plan.push_back(checked_row(ACT_PUT, payload(16'h7FFF, 16'h8000, 24'hFF00FF),
                                        typed_result(KIND_SAMPLE, 16'h7FFF, 16'h8000,
                                                     24'hFF00FF, '0)));
        test_plan.push_back(checked_row(ACT_PUSH, '0,
                                        typed_result(KIND_TOO_FEW, '0, '0, '0, '0)));
        test_plan.push_back(checked_row(ACT_PUT, payload(16'h8000, 16'h7FFF, 24'h00FF00),
                                        typed_result(KIND_SAMPLE, 16'h8000, 16'h7FFF,
                                                     24'h00FF00, '0)));
        // Open while open drops the puts so far.
        test_plan.push_back(plain_row(ACT_OPEN, '1));
        test_plan.push_back(checked_row(ACT_PUT, '0,
                                        typed_result(KIND_SAMPLE, '0, '0, '0, '0)));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'hFFFF, 16'h0001, 24'h123456)));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h00FF, 16'hFF00, 24'hFFFFFF)));
        test_plan.push_back(checked_row(ACT_PUSH, '0,
                                        typed_result(KIND_FRAME_END, '0, '0, '0, 24'd66)));
        test_plan.push_back(register_row(REG_COLOR_SHIFT, 32'd3));
        test_plan.push_back(register_row(REG_SCAN_SPEED, 32'd1));
        test_plan.push_back(register_row(REG_JITTER_FREE, 32'd1));
        test_plan.push_back(checked_row(ACT_PUSH, '0,
                                        typed_result(KIND_NOT_OPEN, '0, '0, '0, '0)));
        // Shift changed in the middle of a frame.
        test_plan.push_back(plain_row(ACT_OPEN, '0));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h0010, 16'hFFF0, 24'h010203)));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h0020, 16'hFFE0, 24'h040506)));
        test_plan.push_back(register_row(REG_COLOR_SHIFT, 32'd1));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h0030, 16'hFFD0, 24'h070809)));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h0040, 16'hFFC0, 24'h0A0B0C)));
        test_plan.push_back(plain_row(ACT_PUSH, '0));
        // Zero scan speed and the largest shift.
        test_plan.push_back(register_row(REG_SCAN_SPEED, 32'd0));
        test_plan.push_back(register_row(REG_COLOR_SHIFT, 32'd63));
        test_plan.push_back(plain_row(ACT_OPEN, '0));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'h4000, 16'hC000, 24'h800080)));
        test_plan.push_back(plain_row(ACT_PUT, payload(16'hC000, 16'h4000, 24'h7F7F7F)));
        test_plan.push_back(plain_row(ACT_PUSH, '0));

        foreach (test_plan[i])
        begin
            if (test_plan[i].row == ROW_REG_WRITE)
                write_register(test_plan[i].act, test_plan[i].data[31:0]);
            else
            begin
                send_request(test_plan[i].act, test_plan[i].data);
                if (test_plan[i].row == ROW_CHECKED)
                begin
                    void'(results_due.pop_back());
                    results_due.push_back(test_plan[i].want);
                end
            end
        end

        // Random part over several register settings and idling modes.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            write_register(REG_COLOR_SHIFT, (seg % 3 == 0) ? 32'd0 :
                                            (seg % 3 == 1) ? 32'd63 : $urandom_range(1, 62));
            case (seg % 4)
                0: speed = 32'd1;
                1: speed = SPEED_MAX;
                2: speed = $urandom_range(1, SPEED_MAX);
                default: speed = $urandom_range(SPEED_MAX) >> $urandom_range(19);
            endcase
            write_register(REG_SCAN_SPEED, speed);
            write_register(REG_JITTER_FREE, seg % 2);
            case (seg % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 86;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 86;
                end
                default:
                begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            // Long receiver hold-off while requests keep coming.
            if (seg == 4)
                hold_request = HOLD_CYCLES;
            goal = requests_sent + RANDOM_REQUESTS / SEGMENTS;
            while (requests_sent < goal)
                random_burst();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (END_GAP) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
